[design/bcf_pkg.sv]
// Shared types and constants for the cubic Bezier flattener.
`timescale 1ns / 1ps

package bcf_pkg;

    // Fixed widths of the interface words.
    localparam int PT_W  = 12;
    localparam int OUT_W = 16;
    localparam int SEG_W = 6;

    localparam logic [SEG_W-1:0] SEG_RESET = 6'd22;

    // Last step of the per-vertex multiply schedule (the drain cycle).
    localparam int CALC_LAST = 14;

    // Operation carried by the shared multiplier, tagged again at writeback.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_UU,
        OP_TT,
        OP_W1,
        OP_W2,
        OP_W3,
        OP_W4,
        OP_X0,
        OP_X1,
        OP_X2,
        OP_X3,
        OP_Y0,
        OP_Y1,
        OP_Y2,
        OP_Y3
    } op_t;

    // Which value goes into the output register.
    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_CURVE
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      div_first;
        logic      t_step;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        op_t       op;
    } dp_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [SEG_W-1:0] n;
    } dp_status_t;

endpackage

[design/bcf_ctrl.sv]
// Controller state machine of the cubic Bezier flattener.
`timescale 1ns / 1ps

module bcf_ctrl #(
    parameter int FRAC_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bcf_pkg::dp_status_t status,
    output bcf_pkg::dp_cmd_t    cmd
);
    import bcf_pkg::*;

    localparam int CNT_W = ($clog2(FRAC_BITS + 1) > 4) ? $clog2(FRAC_BITS + 1) : 4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EMIT = 4'b0100,
        S_CALC = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEG_W-1:0] i_reg, i_next;

    // Multiplier schedule for one interior vertex: squares, weights, then
    // the four weighted points for x and for y.
    function automatic op_t op_for(input logic [3:0] step);
        op_t op;
        case (step)
            4'd0:    op = OP_UU;
            4'd1:    op = OP_TT;
            4'd2:    op = OP_W1;
            4'd3:    op = OP_W2;
            4'd4:    op = OP_W3;
            4'd5:    op = OP_W4;
            4'd6:    op = OP_X0;
            4'd7:    op = OP_X1;
            4'd8:    op = OP_X2;
            4'd9:    op = OP_X3;
            4'd10:   op = OP_Y0;
            4'd11:   op = OP_Y1;
            4'd12:   op = OP_Y2;
            4'd13:   op = OP_Y3;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        cmd        = '0;
        cmd.sel    = SEL_START;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    i_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (i_reg == status.n);
                    if (i_reg == '0)
                        cmd.sel = SEL_START;
                    else if (i_reg == status.n)
                        cmd.sel = SEL_END;
                    else
                        cmd.sel = SEL_CURVE;
                    if (i_reg == status.n)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.t_step = 1'b1;
                        i_next     = i_reg + 1'b1;
                        cnt_next   = '0;
                        state_next = ((i_reg + 1'b1) == status.n) ? S_EMIT : S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                cmd.op = op_for(cnt_reg[3:0]);
                if (cnt_reg == CNT_W'(CALC_LAST))
                    state_next = S_EMIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // A vertex is only handed over when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("vertex issued while output register is occupied");

    // The vertex index never runs past the segment count of the curve.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg <= status.n))
        else $error("vertex index beyond segment count");

    // An accepted curve always starts with the reciprocal division.
    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_DIV && cnt_reg == '0))
        else $error("accepted curve did not enter the divide phase");

endmodule

[design/bcf_datapath.sv]
// Datapath of the cubic Bezier flattener: divider, t stepper, multiplier, output.
`timescale 1ns / 1ps

module bcf_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bcf_pkg::SEG_W-1:0]    cfg_data,
    input  logic [bcf_pkg::PT_W-1:0]     start_x,
    input  logic [bcf_pkg::PT_W-1:0]     start_y,
    input  logic [bcf_pkg::PT_W-1:0]     ctrl_a_x,
    input  logic [bcf_pkg::PT_W-1:0]     ctrl_a_y,
    input  logic [bcf_pkg::PT_W-1:0]     ctrl_b_x,
    input  logic [bcf_pkg::PT_W-1:0]     ctrl_b_y,
    input  logic [bcf_pkg::PT_W-1:0]     end_x,
    input  logic [bcf_pkg::PT_W-1:0]     end_y,
    input  bcf_pkg::dp_cmd_t             cmd,
    output bcf_pkg::dp_status_t          status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bcf_pkg::OUT_W-1:0]    vertex_x,
    output logic [bcf_pkg::OUT_W-1:0]    vertex_y,
    output logic                         last_vertex
);
    import bcf_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int ACC_W = F + PT_W + 2;
    localparam logic [PT_W-1:0] COORD_MASK =
        (COORD_BITS >= PT_W) ? {PT_W{1'b1}} : PT_W'((13'd1 << COORD_BITS) - 13'd1);
    localparam logic [F:0] ONE_Q = (F + 1)'(1) << F;

    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] n_reg;
    logic [PT_W-1:0]  px_reg [4];
    logic [PT_W-1:0]  py_reg [4];

    // Reciprocal division and t stepping.
    logic [SEG_W-1:0] drem_reg;
    logic [F:0]       q_reg;
    logic [SEG_W-1:0] trem_reg;
    logic [F:0]       t_reg;
    logic [SEG_W:0]   div_trial;
    logic             div_ge;
    logic [SEG_W:0]   trem_sum;
    logic             trem_carry;
    logic [F:0]       u_full;

    // Multiplier and intermediate values.
    logic [F-1:0]     t_op, u_op;
    logic [F-1:0]     uu_reg, tt_reg, w1_reg, w2_reg, w3_reg, w4_reg;
    logic [F-1:0]     mul_a, mul_b;
    logic [2*F-1:0]   prod_reg;
    logic [2*F+1:0]   prod3;
    op_t              wb_op_reg;
    logic [ACC_W-1:0] acc_x_reg, acc_y_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] vx_reg, vy_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= SEG_RESET;
        else if (cfg_we)
            seg_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= SEG_W'(1);
        else if (cmd.load)
            n_reg <= (seg_reg == '0) ? SEG_W'(1) : seg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg[0] <= start_x  & COORD_MASK;
            py_reg[0] <= start_y  & COORD_MASK;
            px_reg[1] <= ctrl_a_x & COORD_MASK;
            py_reg[1] <= ctrl_a_y & COORD_MASK;
            px_reg[2] <= ctrl_b_x & COORD_MASK;
            py_reg[2] <= ctrl_b_y & COORD_MASK;
            px_reg[3] <= end_x    & COORD_MASK;
            py_reg[3] <= end_y    & COORD_MASK;
        end
    end

    // Restoring division of 2^F by n, one quotient bit per step.
    assign div_trial = {drem_reg, cmd.div_first};
    assign div_ge    = (div_trial >= {1'b0, n_reg});

    // t advances by the quotient, plus one when the remainder wraps.
    assign trem_sum   = {1'b0, trem_reg} + {1'b0, drem_reg};
    assign trem_carry = (trem_sum >= {1'b0, n_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            drem_reg <= '0;
            q_reg    <= '0;
            trem_reg <= '0;
            t_reg    <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                drem_reg <= div_ge ? SEG_W'(div_trial - {1'b0, n_reg}) : div_trial[SEG_W-1:0];
                q_reg    <= {q_reg[F-1:0], div_ge};
            end
            if (cmd.t_step)
            begin
                trem_reg <= trem_carry ? SEG_W'(trem_sum - {1'b0, n_reg})
                                       : trem_sum[SEG_W-1:0];
                t_reg    <= t_reg + q_reg + (F + 1)'(trem_carry);
            end
        end
    end

    assign u_full = ONE_Q - t_reg;
    assign t_op   = t_reg[F-1:0];
    assign u_op   = u_full[F-1:0];

    always_comb
    begin
        case (cmd.op)
            OP_UU:   begin mul_a = u_op;   mul_b = u_op;             end
            OP_TT:   begin mul_a = t_op;   mul_b = t_op;             end
            OP_W1:   begin mul_a = uu_reg; mul_b = u_op;             end
            OP_W2:   begin mul_a = uu_reg; mul_b = t_op;             end
            OP_W3:   begin mul_a = u_op;   mul_b = tt_reg;           end
            OP_W4:   begin mul_a = tt_reg; mul_b = t_op;             end
            OP_X0:   begin mul_a = w1_reg; mul_b = F'(px_reg[0]);    end
            OP_X1:   begin mul_a = w2_reg; mul_b = F'(px_reg[1]);    end
            OP_X2:   begin mul_a = w3_reg; mul_b = F'(px_reg[2]);    end
            OP_X3:   begin mul_a = w4_reg; mul_b = F'(px_reg[3]);    end
            OP_Y0:   begin mul_a = w1_reg; mul_b = F'(py_reg[0]);    end
            OP_Y1:   begin mul_a = w2_reg; mul_b = F'(py_reg[1]);    end
            OP_Y2:   begin mul_a = w3_reg; mul_b = F'(py_reg[2]);    end
            OP_Y3:   begin mul_a = w4_reg; mul_b = F'(py_reg[3]);    end
            default: begin mul_a = '0;     mul_b = '0;               end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_op_reg <= OP_NONE;
        else
            wb_op_reg <= cmd.op;
    end

    // Three times the product, for the two middle Bernstein weights.
    assign prod3 = {1'b0, prod_reg, 1'b0} + {2'b00, prod_reg};

    always_ff @(posedge clk)
    begin
        case (wb_op_reg)
            OP_UU:   uu_reg    <= prod_reg[F +: F];
            OP_TT:   tt_reg    <= prod_reg[F +: F];
            OP_W1:   w1_reg    <= prod_reg[F +: F];
            OP_W2:   w2_reg    <= prod3[F +: F];
            OP_W3:   w3_reg    <= prod3[F +: F];
            OP_W4:   w4_reg    <= prod_reg[F +: F];
            OP_X0:   acc_x_reg <= ACC_W'(prod_reg);
            OP_X1,
            OP_X2,
            OP_X3:   acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
            OP_Y0:   acc_y_reg <= ACC_W'(prod_reg);
            OP_Y1,
            OP_Y2,
            OP_Y3:   acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg <= cmd.last;
            case (cmd.sel)
                SEL_START:
                begin
                    vx_reg <= {px_reg[0], 4'b0000};
                    vy_reg <= {py_reg[0], 4'b0000};
                end
                SEL_END:
                begin
                    vx_reg <= {px_reg[3], 4'b0000};
                    vy_reg <= {py_reg[3], 4'b0000};
                end
                default:
                begin
                    vx_reg <= acc_x_reg[F-4 +: OUT_W];
                    vy_reg <= acc_y_reg[F-4 +: OUT_W];
                end
            endcase
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.n        = n_reg;
    assign out_valid       = out_valid_reg;
    assign vertex_x        = vx_reg;
    assign vertex_y        = vy_reg;
    assign last_vertex     = last_reg;

    // A curve vertex leaves only after the accumulators have taken every product.
    a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel == SEL_CURVE) |-> (wb_op_reg == OP_NONE))
        else $error("curve vertex emitted with products still in flight");

    // t only moves between vertices, never while the multiplier is busy.
    a_t_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.t_step |-> (cmd.op == OP_NONE && wb_op_reg == OP_NONE))
        else $error("t advanced during multiply schedule");

endmodule

[design/cubic_bezier_flattener_core.sv]
// Top level of the cubic Bezier flattener: config register port, controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// in        input      in_valid/in_stall  one curve: start, ctrl_a, ctrl_b, end points (12 bits)
// out       output     out_valid/out_stall one vertex: vertex_x, vertex_y, last_vertex
// cfg       input      cfg_valid/cfg_ready segment_count (6 bits), always ready
//
// A curve starts with the bit-serial division that yields the t increment; each of its
// n - 1 interior vertices, where n is the segment count (zero counts as one), then takes
// 14 products through the one shared multiplier, a drain step and the load of the
// output register.
// Reset is asynchronous and active low; it restores the segment count to 22.
// A stall on the output holds the current vertex and pauses the controller before
// the next vertex; in_stall stays high from acceptance until the last vertex is loaded.

module cubic_bezier_flattener_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bcf_pkg::SEG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bcf_pkg::PT_W-1:0]  start_x,
    input  logic [bcf_pkg::PT_W-1:0]  start_y,
    input  logic [bcf_pkg::PT_W-1:0]  ctrl_a_x,
    input  logic [bcf_pkg::PT_W-1:0]  ctrl_a_y,
    input  logic [bcf_pkg::PT_W-1:0]  ctrl_b_x,
    input  logic [bcf_pkg::PT_W-1:0]  ctrl_b_y,
    input  logic [bcf_pkg::PT_W-1:0]  end_x,
    input  logic [bcf_pkg::PT_W-1:0]  end_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bcf_pkg::OUT_W-1:0] vertex_x,
    output logic [bcf_pkg::OUT_W-1:0] vertex_y,
    output logic                      last_vertex
);
    import bcf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    // The segment count register takes a word on any cycle; the host must write it only
    // between curves, which the block itself does not enforce.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller sequences division, per-vertex multiply schedule and output.
    bcf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the points, steps t = i/n in fixed point, forms the
    // Bernstein weights and weighted sums, and owns the output register.
    bcf_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .ctrl_a_x    (ctrl_a_x),
        .ctrl_a_y    (ctrl_a_y),
        .ctrl_b_x    (ctrl_b_x),
        .ctrl_b_y    (ctrl_b_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the cubic Bezier flattener core.
`timescale 1ns / 1ps

module tb_top;

    import bcf_pkg::*;

    localparam int FRAC_Q = 24;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_Q;

    // Cycles the vertex sink refuses words in one go to back up the core.
    localparam int LONG_HOLD = 600;
    // Quiet cycles after the last vertex before the verdict.
    localparam int SETTLE = 64;
    // Watchdog limit in nanoseconds, well above the slowest legal run of this stimulus.
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    typedef struct packed {
        logic [PT_W-1:0] sx;
        logic [PT_W-1:0] sy;
        logic [PT_W-1:0] ax;
        logic [PT_W-1:0] ay;
        logic [PT_W-1:0] bx;
        logic [PT_W-1:0] by;
        logic [PT_W-1:0] ex;
        logic [PT_W-1:0] ey;
    } curve_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             last;
    } vertex_t;

    // One directed curve. Where the strip is only two vertices long, both are typed
    // in here; every other row goes through the predictor.
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             typed;
        curve_t           pts;
        vertex_t          first_v;
        vertex_t          final_v;
    } plan_row_t;

    localparam vertex_t NO_V = '0;
    localparam int N_PLAN = 15;

    localparam plan_row_t PLAN [N_PLAN] = '{
        // Reset segment count, extremes and alternating bit patterns.
        '{6'd22, 1'b0, '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                         12'h000, 12'h000}, NO_V, NO_V},
        '{6'd22, 1'b0, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                         12'hFFF, 12'hFFF}, NO_V, NO_V},
        '{6'd22, 1'b0, '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF,
                         12'hFFF, 12'h000}, NO_V, NO_V},
        '{6'd22, 1'b0, '{12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'h555,
                         12'h555, 12'hAAA}, NO_V, NO_V},
        '{6'd22, 1'b0, '{12'h800, 12'h001, 12'h7FF, 12'hFFE, 12'h001, 12'h800,
                         12'hFFE, 12'h7FF}, NO_V, NO_V},
        // A zero segment count behaves as one: just the start and end points.
        '{6'd0, 1'b1, '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                        12'h000, 12'h000},
          '{16'h0000, 16'h0000, 1'b0}, '{16'h0000, 16'h0000, 1'b1}},
        '{6'd0, 1'b1, '{12'hFFF, 12'hFFF, 12'h123, 12'h456, 12'h789, 12'hABC,
                        12'h000, 12'h000},
          '{16'hFFF0, 16'hFFF0, 1'b0}, '{16'h0000, 16'h0000, 1'b1}},
        '{6'd0, 1'b1, '{12'h000, 12'h001, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        12'hFFF, 12'h800},
          '{16'h0000, 16'h0010, 1'b0}, '{16'hFFF0, 16'h8000, 1'b1}},
        '{6'd1, 1'b1, '{12'hAAA, 12'h555, 12'h000, 12'hFFF, 12'hFFF, 12'h000,
                        12'h555, 12'hAAA},
          '{16'hAAA0, 16'h5550, 1'b0}, '{16'h5550, 16'hAAA0, 1'b1}},
        '{6'd1, 1'b1, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        12'hFFF, 12'hFFF},
          '{16'hFFF0, 16'hFFF0, 1'b0}, '{16'hFFF0, 16'hFFF0, 1'b1}},
        // Longest strips.
        '{6'd63, 1'b0, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                         12'hFFF, 12'hFFF}, NO_V, NO_V},
        '{6'd63, 1'b0, '{12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000,
                         12'h000, 12'h000}, NO_V, NO_V},
        // Short strips and the midpoint of a straight diagonal.
        '{6'd2, 1'b0, '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        12'h000, 12'h000}, NO_V, NO_V},
        '{6'd3, 1'b0, '{12'h100, 12'h200, 12'h300, 12'h400, 12'h500, 12'h600,
                        12'h700, 12'h800}, NO_V, NO_V},
        '{6'd32, 1'b0, '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                         12'hFFF, 12'hFFF}, NO_V, NO_V}
    };

    // Random phases: segment count (-1 draws one from 0 to 20) and number of curves.
    // Long strips get only a few curves so the run stays short.
    localparam int N_PHASE = 10;
    localparam int PHASE_SEG [N_PHASE]   = '{3, 0, 7, 63, 1, 12, 2, -1, 40, 5};
    localparam int PHASE_ITEMS [N_PHASE] = '{14, 14, 12, 4, 14, 12, 14, 14, 4, 12};
    // Phases run with no idling on either side, and the one with the long hold.
    localparam int BURST_A = 2;
    localparam int BURST_B = 4;
    localparam int HOLD_PHASE = 6;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [SEG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [PT_W-1:0]  start_x;
    logic [PT_W-1:0]  start_y;
    logic [PT_W-1:0]  ctrl_a_x;
    logic [PT_W-1:0]  ctrl_a_y;
    logic [PT_W-1:0]  ctrl_b_x;
    logic [PT_W-1:0]  ctrl_b_y;
    logic [PT_W-1:0]  end_x;
    logic [PT_W-1:0]  end_y;
    logic             out_valid;
    logic             out_stall;
    logic [OUT_W-1:0] vertex_x;
    logic [OUT_W-1:0] vertex_y;
    logic             last_vertex;

    // Shadow of the segment count register, as the core should hold it.
    logic [SEG_W-1:0] seg_now;
    // Vertices still owed by the core, oldest first.
    vertex_t          pending_vertices [$];
    int               mismatches;
    // Set by the stimulus; the sink clears hold_out once it has served the hold.
    logic             no_idle;
    logic             hold_out;

    always #4 clk = ~clk;

    cubic_bezier_flattener_core #(
        .COORD_BITS(12),
        .FRAC_BITS (FRAC_Q)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .ctrl_a_x   (ctrl_a_x),
        .ctrl_a_y   (ctrl_a_y),
        .ctrl_b_x   (ctrl_b_x),
        .ctrl_b_y   (ctrl_b_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .last_vertex(last_vertex)
    );

    // Bernstein blend of one axis at parameter t (Q0.24), in sixteenths of a pixel.
    // Each weight is truncated on its own before the weighted sum.
    function automatic logic [OUT_W-1:0] bezier_coord(
        input logic [63:0]     t,
        input logic [PT_W-1:0] p0,
        input logic [PT_W-1:0] p1,
        input logic [PT_W-1:0] p2,
        input logic [PT_W-1:0] p3
    );
        logic [63:0] u, uu, tt, w1, w2, w3, w4, acc;
        u   = ONE_Q - t;
        uu  = (u * u) >> FRAC_Q;
        tt  = (t * t) >> FRAC_Q;
        w1  = (uu * u) >> FRAC_Q;
        w2  = (64'd3 * uu * t) >> FRAC_Q;
        w3  = (64'd3 * u * tt) >> FRAC_Q;
        w4  = (tt * t) >> FRAC_Q;
        acc = w1 * p0 + w2 * p1 + w3 * p2 + w4 * p3;
        acc = (acc << 4) >> FRAC_Q;
        return acc[OUT_W-1:0];
    endfunction

    // Queues the whole line strip that one curve should produce at the current
    // segment count. The end points are exact; only interior vertices are blended.
    function automatic void flatten_curve(input curve_t c);
        logic [63:0] n, t;
        vertex_t     v;
        n = (seg_now == '0) ? 64'd1 : 64'(seg_now);
        for (longint unsigned i = 0; i <= n; i++) begin
            if (i == 0) begin
                v = {c.sx, 4'h0, c.sy, 4'h0, 1'b0};
            end else if (i == n) begin
                v = {c.ex, 4'h0, c.ey, 4'h0, 1'b1};
            end else begin
                t = (64'(i) << FRAC_Q) / n;
                v = {bezier_coord(t, c.sx, c.ax, c.bx, c.ex),
                     bezier_coord(t, c.sy, c.ay, c.by, c.ey), 1'b0};
            end
            pending_vertices.push_back(v);
        end
    endfunction

    // Edge values show up often so the corners of the range keep getting hit.
    function automatic logic [PT_W-1:0] pick_coord();
        logic [PT_W-1:0] p;
        case ($urandom_range(7, 0))
            0:       p = '0;
            1:       p = '1;
            default: p = PT_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic curve_t random_curve();
        curve_t c;
        c.sx = pick_coord();
        c.sy = pick_coord();
        c.ax = pick_coord();
        c.ay = pick_coord();
        c.bx = pick_coord();
        c.by = pick_coord();
        c.ex = pick_coord();
        c.ey = pick_coord();
        return c;
    endfunction

    // Offers one curve after a random gap, or none with no_idle set, and returns at the edge that takes it.
    // Valid stays high after that edge, so a following curve with no gap goes out
    // back to back; anyone who stops sending must lower it.
    task automatic offer_curve(input curve_t c);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(14, 0));
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start_x  <= c.sx;
        start_y  <= c.sy;
        ctrl_a_x <= c.ax;
        ctrl_a_y <= c.ay;
        ctrl_b_x <= c.bx;
        ctrl_b_y <= c.by;
        end_x    <= c.ex;
        end_y    <= c.ey;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops sending and waits for every owed vertex, leaving the core idle.
    task automatic drain_strips();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
    endtask

    task automatic write_seg_count(input logic [SEG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        seg_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Vertex sink: draws a stall for every word unless no_idle is set, serves the long hold when asked,
    // and checks each accepted word against the oldest owed vertex.
    initial begin : vertex_sink
        int      gap;
        vertex_t seen;
        vertex_t want;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            gap = no_idle ? 0 : int'($urandom_range(14, 0));
            @(negedge clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_out = 1'b0;
            end else if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            seen = {vertex_x, vertex_y, last_vertex};
            if (pending_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: vertex with none owed: x=%0d y=%0d last=%0b",
                             $realtime, seen.x, seen.y, seen.last);
            end else begin
                want = pending_vertices.pop_front();
                if (seen != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: vertex mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 $realtime, want.x, want.y, want.last,
                                 seen.x, seen.y, seen.last);
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t        row;
        curve_t           c;
        logic [SEG_W-1:0] seg;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        start_x   = '0;
        start_y   = '0;
        ctrl_a_x  = '0;
        ctrl_a_y  = '0;
        ctrl_b_x  = '0;
        ctrl_b_y  = '0;
        end_x     = '0;
        end_y     = '0;
        no_idle   = 1'b0;
        hold_out  = 1'b0;
        mismatches = 0;
        seg_now   = SEG_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed curves. The first rows run at the reset segment count with no
        // write at all; the register is rewritten only between idle stretches.
        for (int r = 0; r < N_PLAN; r++) begin
            row = PLAN[r];
            if (row.seg != seg_now) begin
                drain_strips();
                write_seg_count(row.seg);
            end
            offer_curve(row.pts);
            if (row.typed) begin
                pending_vertices.push_back(row.first_v);
                pending_vertices.push_back(row.final_v);
            end else begin
                flatten_curve(row.pts);
            end
        end

        // Random curves over a spread of segment counts.
        for (int ph = 0; ph < N_PHASE; ph++) begin
            drain_strips();
            if (PHASE_SEG[ph] < 0)
                seg = SEG_W'($urandom_range(20, 0));
            else
                seg = SEG_W'(PHASE_SEG[ph]);
            write_seg_count(seg);
            no_idle = (ph == BURST_A) || (ph == BURST_B);
            // The sink sits on its input for a long stretch while curves keep
            // coming, so the core must hold its output and push back on its input.
            if (ph == HOLD_PHASE)
                hold_out = 1'b1;
            for (int k = 0; k < PHASE_ITEMS[ph]; k++) begin
                c = random_curve();
                offer_curve(c);
                flatten_curve(c);
            end
        end

        drain_strips();
        no_idle = 1'b0;
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
design/bcf_pkg.sv
design/bcf_ctrl.sv
design/bcf_datapath.sv
design/cubic_bezier_flattener_core.sv
dv/tb_top.sv
